// File: src/scch_pkg.sv
// Shared constants for the swept circle against circle hit block.
package scch_pkg;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] MIN_MOVE_RESET = 16'd66;

    localparam int TIME_W = 17;
    localparam int TIME_SHIFT = 16;
    localparam logic [TIME_W-1:0] HIT_TIME_ONE = 17'd65536;

    localparam int NORM_W = 16;
    localparam int NORM_SHIFT = 14;
    localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;
    localparam logic signed [NORM_W-1:0] NORM_MINUS_ONE = -16'sd16384;

endpackage

// File: src/scch_div.sv
// Pipelined signed divider, rounded half away from zero, one quotient bit per stage.
module scch_div #(
    parameter int NW = 67,
    parameter int DW = 33,
    parameter int QW = 34,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic signed [QW:0]   quo,
    output logic [SW-1:0]        side_out
);

    localparam int RW = ((NW > DW) ? NW : DW) + 1;
    localparam int CW = (RW > DW + QW) ? RW : DW + QW;

    logic [CW-1:0] rem_reg [0:QW];
    logic [QW-1:0] q_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          neg_reg [0:QW];
    logic          vld_reg [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    logic [NW-1:0] mag;
    assign mag = num[NW-1] ? NW'(-num) : NW'(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(mag) + CW'(den >> 1);
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            neg_reg[0]  <= num[NW-1];
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        localparam int SH = QW - k;
        logic [CW-1:0] trial;
        logic          take;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] q_next;

        assign trial    = CW'(den_reg[k-1]) << SH;
        assign take     = rem_reg[k-1] >= trial;
        assign rem_next = take ? rem_reg[k-1] - trial : rem_reg[k-1];
        assign q_next   = (q_reg[k-1] << 1) | QW'(take);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    logic signed [QW:0] q_ext;
    assign q_ext     = $signed({1'b0, q_reg[QW]});
    assign quo       = neg_reg[QW] ? -q_ext : q_ext;
    assign out_valid = vld_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// File: src/scch_sqrt.sv
// Pipelined integer square root, floor of the root, one result bit per stage.
module scch_sqrt #(
    parameter int IW = 66,
    parameter int SW = 1,
    localparam int OW = (IW + 1) / 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [IW-1:0] val,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [OW-1:0] root,
    output logic [SW-1:0] side_out
);

    localparam int TW = 2 * OW + 1;

    logic [TW-1:0] rem_reg [0:OW];
    logic [OW-1:0] root_reg [0:OW];
    logic          vld_reg [0:OW];
    logic [SW-1:0] side_reg [0:OW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= TW'(val);
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= OW; k++)
    begin : g_step
        localparam int BI = OW - k;
        logic [TW-1:0] trial;
        logic          take;
        logic [TW-1:0] rem_next;
        logic [OW-1:0] root_next;

        assign trial     = (TW'(root_reg[k-1]) << (BI + 1)) | (TW'(1) << (2 * BI));
        assign take      = rem_reg[k-1] >= trial;
        assign rem_next  = take ? rem_reg[k-1] - trial : rem_reg[k-1];
        assign root_next = root_reg[k-1] | (OW'(take) << BI);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[OW];
    assign root      = root_reg[OW];
    assign side_out  = side_reg[OW];

endmodule

// File: src/swept_circle_vs_circle_hit.sv
// Top level of the swept circle against circle hit pipeline.
//
//  Channel | Direction | Handshake               | Payload
//  s_axis  | in        | s_axis_tvalid/tready    | tdata: query coordinates and radii
//  m_axis  | out       | m_axis_tvalid/tready    | tdata: hit results, tuser: hit flag
//  cfg     | in        | cfg_valid/cfg_ready     | cfg_data: min_move_distance
//
// One transaction is accepted per cycle while the output register is empty or being read.
// Most of the pipeline depth comes from three bit-serial square root pipelines and three divider pipelines
// that lie in series.
// All stages advance together whenever the output register is empty or being read.
// Reset clears every valid bit and loads min_move_distance with 66.
module swept_circle_vs_circle_hit
    import scch_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // start_x, start_y, end_x, end_y, mover_radius, other_x, other_y, other_radius
    input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // hit_time, hit_distance, impact_x, impact_y, normal_x, normal_y
    output logic [((3*COORD_WIDTH+48+7)/8)*8-1:0] m_axis_tdata,
    // hit
    output logic                m_axis_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int DWID   = W + 1;
    localparam int SPW    = 2 * DWID;
    localparam int SUMW   = SPW + 1;
    localparam int PRW    = W + 3;
    localparam int TW     = W + 4;
    localparam int MXW    = 2 * DWID + 1;
    localparam int IXW    = W + 4;
    localparam int VW     = W + 5;
    localparam int NNW    = VW + NORM_SHIFT;
    localparam int NQW    = NORM_W - 1;
    localparam int OUT_DW = ((3 * W + 48 + 7) / 8) * 8;

    localparam logic signed [IXW-1:0] MAXC = $signed({{(IXW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [IXW-1:0] MINC = $signed({{(IXW-W+1){1'b1}}, {(W-1){1'b0}}});
    localparam logic [DWID-1:0]       RMAX = {2'b00, {(W-1){1'b1}}};

    typedef struct packed {
        logic signed [SUMW-1:0] dot;
        logic signed [SUMW-1:0] crs;
        logic signed [DWID-1:0] dx;
        logic signed [DWID-1:0] dy;
        logic signed [W-1:0]    sx;
        logic signed [W-1:0]    sy;
        logic signed [W-1:0]    ox;
        logic signed [W-1:0]    oy;
        logic [W-1:0]           rad;
    } sb1_t;

    typedef struct packed {
        logic                   short_mv;
        logic [DWID-1:0]        len;
        logic signed [DWID-1:0] dx;
        logic signed [DWID-1:0] dy;
        logic signed [W-1:0]    sx;
        logic signed [W-1:0]    sy;
        logic signed [W-1:0]    ox;
        logic signed [W-1:0]    oy;
        logic [W-1:0]           rad;
    } sb2_t;

    typedef struct packed {
        logic                   miss;
        logic signed [PRW-1:0]  proj;
        logic [DWID-1:0]        len;
        logic signed [DWID-1:0] dx;
        logic signed [DWID-1:0] dy;
        logic signed [W-1:0]    sx;
        logic signed [W-1:0]    sy;
        logic signed [W-1:0]    ox;
        logic signed [W-1:0]    oy;
    } sb3_t;

    typedef struct packed {
        logic                   miss;
        logic [DWID-1:0]        tu;
        logic signed [W-1:0]    sx;
        logic signed [W-1:0]    sy;
        logic signed [W-1:0]    ox;
        logic signed [W-1:0]    oy;
    } sb4_t;

    typedef struct packed {
        logic                   miss;
        logic [TIME_W-1:0]      ht;
        logic [W-2:0]           hit_dist;
        logic signed [W-1:0]    impx;
        logic signed [W-1:0]    impy;
        logic signed [VW-1:0]   vx;
        logic signed [VW-1:0]   vy;
    } sb5_t;

    typedef struct packed {
        logic                   miss;
        logic                   zmag;
        logic [TIME_W-1:0]      ht;
        logic [W-2:0]           hit_dist;
        logic signed [W-1:0]    impx;
        logic signed [W-1:0]    impy;
    } sb6_t;

    logic en;
    logic out_vld_reg;
    logic [CFG_W-1:0] min_move_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_move_reg <= MIN_MOVE_RESET;
        end
        else if (cfg_valid)
        begin
            min_move_reg <= cfg_data;
        end
    end

    logic signed [W-1:0] start_x, start_y, end_x, end_y, other_x, other_y;
    logic [W-2:0]        mover_radius, other_radius;

    assign start_x      = s_axis_tdata[W-1:0];
    assign start_y      = s_axis_tdata[2*W-1:W];
    assign end_x        = s_axis_tdata[3*W-1:2*W];
    assign end_y        = s_axis_tdata[4*W-1:3*W];
    assign mover_radius = s_axis_tdata[5*W-2:4*W];
    assign other_x      = s_axis_tdata[6*W-2:5*W-1];
    assign other_y      = s_axis_tdata[7*W-2:6*W-1];
    assign other_radius = s_axis_tdata[8*W-3:7*W-1];

    // Stage A: differences and radius sum.
    logic                   a_vld_reg;
    logic signed [W-1:0]    a_sx_reg, a_sy_reg, a_ox_reg, a_oy_reg;
    logic signed [DWID-1:0] a_dx_reg, a_dy_reg, a_cx_reg, a_cy_reg;
    logic [W-1:0]           a_rad_reg;

    // Stage B: products.
    logic                   b_vld_reg;
    logic signed [W-1:0]    b_sx_reg, b_sy_reg, b_ox_reg, b_oy_reg;
    logic signed [DWID-1:0] b_dx_reg, b_dy_reg;
    logic [W-1:0]           b_rad_reg;
    logic signed [SPW-1:0]  b_dxx_reg, b_dyy_reg, b_cxdx_reg, b_cydy_reg, b_cxdy_reg, b_cydx_reg;

    // Stage C: sums.
    logic                   c_vld_reg;
    logic [SPW-1:0]         c_lsq_reg;
    sb1_t                   c_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= s_axis_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sx_reg   <= start_x;
            a_sy_reg   <= start_y;
            a_ox_reg   <= other_x;
            a_oy_reg   <= other_y;
            a_dx_reg   <= DWID'(end_x) - DWID'(start_x);
            a_dy_reg   <= DWID'(end_y) - DWID'(start_y);
            a_cx_reg   <= DWID'(other_x) - DWID'(start_x);
            a_cy_reg   <= DWID'(other_y) - DWID'(start_y);
            a_rad_reg  <= W'(mover_radius) + W'(other_radius);

            b_sx_reg   <= a_sx_reg;
            b_sy_reg   <= a_sy_reg;
            b_ox_reg   <= a_ox_reg;
            b_oy_reg   <= a_oy_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_rad_reg  <= a_rad_reg;
            b_dxx_reg  <= a_dx_reg * a_dx_reg;
            b_dyy_reg  <= a_dy_reg * a_dy_reg;
            b_cxdx_reg <= a_cx_reg * a_dx_reg;
            b_cydy_reg <= a_cy_reg * a_dy_reg;
            b_cxdy_reg <= a_cx_reg * a_dy_reg;
            b_cydx_reg <= a_cy_reg * a_dx_reg;

            c_lsq_reg    <= SPW'(b_dxx_reg) + SPW'(b_dyy_reg);
            c_sb_reg.dot <= SUMW'(b_cxdx_reg) + SUMW'(b_cydy_reg);
            c_sb_reg.crs <= SUMW'(b_cxdy_reg) - SUMW'(b_cydx_reg);
            c_sb_reg.dx  <= b_dx_reg;
            c_sb_reg.dy  <= b_dy_reg;
            c_sb_reg.sx  <= b_sx_reg;
            c_sb_reg.sy  <= b_sy_reg;
            c_sb_reg.ox  <= b_ox_reg;
            c_sb_reg.oy  <= b_oy_reg;
            c_sb_reg.rad <= b_rad_reg;
        end
    end

    // Move length.
    logic            s1_vld;
    logic [DWID-1:0] s1_len;
    sb1_t            s1_sb;

    scch_sqrt #(.IW(SPW), .SW($bits(sb1_t))) u_sqrt_len (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c_vld_reg), .val(c_lsq_reg),
        .side_in(c_sb_reg), .out_valid(s1_vld), .root(s1_len), .side_out(s1_sb)
    );

    // Projection and perpendicular offset.
    sb2_t             d_sb_in, d_sb;
    logic             d_vld;
    logic signed [PRW-1:0] d_proj, d_perp;

    always_comb
    begin
        d_sb_in.short_mv = (s1_len == '0) || (s1_len < DWID'(min_move_reg));
        d_sb_in.len      = s1_len;
        d_sb_in.dx       = s1_sb.dx;
        d_sb_in.dy       = s1_sb.dy;
        d_sb_in.sx       = s1_sb.sx;
        d_sb_in.sy       = s1_sb.sy;
        d_sb_in.ox       = s1_sb.ox;
        d_sb_in.oy       = s1_sb.oy;
        d_sb_in.rad      = s1_sb.rad;
    end

    scch_div #(.NW(SUMW), .DW(DWID), .QW(PRW-1), .SW($bits(sb2_t))) u_div_proj (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_vld), .num(s1_sb.dot),
        .den(s1_len), .side_in(d_sb_in), .out_valid(d_vld), .quo(d_proj),
        .side_out(d_sb)
    );

    scch_div #(.NW(SUMW), .DW(DWID), .QW(PRW-1), .SW(1)) u_div_perp (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_vld), .num(s1_sb.crs),
        .den(s1_len), .side_in(1'b0), .out_valid(), .quo(d_perp), .side_out()
    );

    // Stage E: squares of the offset and the radius sum. Stage F: compare.
    logic                  e_vld_reg, f_vld_reg;
    logic [2*PRW-1:0]      e_h2_reg;
    logic [2*W-1:0]        e_r2_reg;
    logic signed [PRW-1:0] e_proj_reg;
    sb2_t                  e_sb_reg;
    logic [2*W-1:0]        f_diff_reg;
    sb3_t                  f_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= d_vld;
            f_vld_reg <= e_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_h2_reg      <= d_perp * d_perp;
            e_r2_reg      <= d_sb.rad * d_sb.rad;
            e_proj_reg    <= d_proj;
            e_sb_reg      <= d_sb;

            f_diff_reg    <= e_r2_reg - e_h2_reg[2*W-1:0];
            f_sb_reg.miss <= e_sb_reg.short_mv || (e_h2_reg > (2*PRW)'(e_r2_reg));
            f_sb_reg.proj <= e_proj_reg;
            f_sb_reg.len  <= e_sb_reg.len;
            f_sb_reg.dx   <= e_sb_reg.dx;
            f_sb_reg.dy   <= e_sb_reg.dy;
            f_sb_reg.sx   <= e_sb_reg.sx;
            f_sb_reg.sy   <= e_sb_reg.sy;
            f_sb_reg.ox   <= e_sb_reg.ox;
            f_sb_reg.oy   <= e_sb_reg.oy;
        end
    end

    // Half chord.
    logic         s2_vld;
    logic [W-1:0] s2_off;
    sb3_t         s2_sb;

    scch_sqrt #(.IW(2*W), .SW($bits(sb3_t))) u_sqrt_off (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_vld_reg), .val(f_diff_reg),
        .side_in(f_sb_reg), .out_valid(s2_vld), .root(s2_off), .side_out(s2_sb)
    );

    // Stage G: hit distance along the ray. Stage H: products for the impact point.
    logic signed [TW-1:0] g_t1, g_t2, g_t;

    assign g_t1 = s2_sb.proj - $signed({1'b0, s2_off});
    assign g_t2 = s2_sb.proj + $signed({1'b0, s2_off});
    assign g_t  = g_t1[TW-1] ? g_t2 : g_t1;

    logic                   g_vld_reg, h_vld_reg;
    logic                   g_miss_reg;
    logic [DWID-1:0]        g_tu_reg, g_len_reg;
    logic signed [DWID-1:0] g_dx_reg, g_dy_reg;
    logic signed [W-1:0]    g_sx_reg, g_sy_reg, g_ox_reg, g_oy_reg;
    logic signed [MXW-1:0]  h_mx_reg, h_my_reg, h_tn_reg;
    logic [DWID-1:0]        h_len_reg;
    sb4_t                   h_sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            g_vld_reg <= s2_vld;
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_miss_reg <= s2_sb.miss || g_t[TW-1] || (g_t > $signed({1'b0, s2_sb.len}));
            g_tu_reg   <= g_t[DWID-1:0];
            g_len_reg  <= s2_sb.len;
            g_dx_reg   <= s2_sb.dx;
            g_dy_reg   <= s2_sb.dy;
            g_sx_reg   <= s2_sb.sx;
            g_sy_reg   <= s2_sb.sy;
            g_ox_reg   <= s2_sb.ox;
            g_oy_reg   <= s2_sb.oy;

            h_mx_reg      <= g_dx_reg * $signed({1'b0, g_tu_reg});
            h_my_reg      <= g_dy_reg * $signed({1'b0, g_tu_reg});
            h_tn_reg      <= $signed(MXW'({g_tu_reg, {TIME_SHIFT{1'b0}}}));
            h_len_reg     <= g_len_reg;
            h_sb_reg.miss <= g_miss_reg;
            h_sb_reg.tu   <= g_tu_reg;
            h_sb_reg.sx   <= g_sx_reg;
            h_sb_reg.sy   <= g_sy_reg;
            h_sb_reg.ox   <= g_ox_reg;
            h_sb_reg.oy   <= g_oy_reg;
        end
    end

    logic                  q_vld;
    logic signed [PRW-1:0] q_x, q_y, q_t;
    sb4_t                  q_sb;

    scch_div #(.NW(MXW), .DW(DWID), .QW(PRW-1), .SW($bits(sb4_t))) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_vld_reg), .num(h_mx_reg),
        .den(h_len_reg), .side_in(h_sb_reg), .out_valid(q_vld), .quo(q_x),
        .side_out(q_sb)
    );

    scch_div #(.NW(MXW), .DW(DWID), .QW(PRW-1), .SW(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_vld_reg), .num(h_my_reg),
        .den(h_len_reg), .side_in(1'b0), .out_valid(), .quo(q_y), .side_out()
    );

    scch_div #(.NW(MXW), .DW(DWID), .QW(PRW-1), .SW(1)) u_div_t (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(h_vld_reg), .num(h_tn_reg),
        .den(h_len_reg), .side_in(1'b0), .out_valid(), .quo(q_t), .side_out()
    );

    // Stage I: impact point. Stage J: saturation and offset from the obstacle.
    // Stage K: squares. Stage L: squared distance.
    logic                  i_vld_reg, j_vld_reg, k_vld_reg, l_vld_reg;
    logic signed [IXW-1:0] i_ix_reg, i_iy_reg;
    logic [TIME_W-1:0]     i_ht_reg;
    sb4_t                  i_sb_reg;
    sb5_t                  j_sb_reg, k_sb_reg, l_sb_reg;
    logic [2*VW-1:0]       k_vxx_reg, k_vyy_reg;
    logic [2*VW-1:0]       l_msq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            i_vld_reg <= q_vld;
            j_vld_reg <= i_vld_reg;
            k_vld_reg <= j_vld_reg;
            l_vld_reg <= k_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_ix_reg <= q_sb.sx + q_x;
            i_iy_reg <= q_sb.sy + q_y;
            i_ht_reg <= q_t[TIME_W-1:0];
            i_sb_reg <= q_sb;

            j_sb_reg.miss     <= i_sb_reg.miss;
            j_sb_reg.ht       <= i_ht_reg;
            j_sb_reg.hit_dist <= (i_sb_reg.tu > RMAX) ? RMAX[W-2:0] : i_sb_reg.tu[W-2:0];
            j_sb_reg.impx     <= (i_ix_reg > MAXC) ? MAXC[W-1:0] :
                                 (i_ix_reg < MINC) ? MINC[W-1:0] : i_ix_reg[W-1:0];
            j_sb_reg.impy     <= (i_iy_reg > MAXC) ? MAXC[W-1:0] :
                                 (i_iy_reg < MINC) ? MINC[W-1:0] : i_iy_reg[W-1:0];
            j_sb_reg.vx       <= i_ix_reg - i_sb_reg.ox;
            j_sb_reg.vy       <= i_iy_reg - i_sb_reg.oy;

            k_vxx_reg <= j_sb_reg.vx * j_sb_reg.vx;
            k_vyy_reg <= j_sb_reg.vy * j_sb_reg.vy;
            k_sb_reg  <= j_sb_reg;

            l_msq_reg <= k_vxx_reg + k_vyy_reg;
            l_sb_reg  <= k_sb_reg;
        end
    end

    // Distance from the obstacle centre.
    logic          s3_vld;
    logic [VW-1:0] s3_mag;
    sb5_t          s3_sb;

    scch_sqrt #(.IW(2*VW), .SW($bits(sb5_t))) u_sqrt_mag (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(l_vld_reg), .val(l_msq_reg),
        .side_in(l_sb_reg), .out_valid(s3_vld), .root(s3_mag), .side_out(s3_sb)
    );

    // Unit normal.
    sb6_t                     n_sb_in, n_sb;
    logic                     n_vld;
    logic signed [NORM_W-1:0] n_qx, n_qy;
    logic signed [NNW-1:0]    n_numx, n_numy;

    assign n_numx = $signed({s3_sb.vx, {NORM_SHIFT{1'b0}}});
    assign n_numy = $signed({s3_sb.vy, {NORM_SHIFT{1'b0}}});

    always_comb
    begin
        n_sb_in.miss     = s3_sb.miss;
        n_sb_in.zmag     = (s3_mag == '0);
        n_sb_in.ht       = s3_sb.ht;
        n_sb_in.hit_dist = s3_sb.hit_dist;
        n_sb_in.impx     = s3_sb.impx;
        n_sb_in.impy     = s3_sb.impy;
    end

    scch_div #(.NW(NNW), .DW(VW), .QW(NQW), .SW($bits(sb6_t))) u_div_nx (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_vld), .num(n_numx),
        .den(s3_mag), .side_in(n_sb_in), .out_valid(n_vld), .quo(n_qx),
        .side_out(n_sb)
    );

    scch_div #(.NW(NNW), .DW(VW), .QW(NQW), .SW(1)) u_div_ny (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_vld), .num(n_numy),
        .den(s3_mag), .side_in(1'b0), .out_valid(), .quo(n_qy), .side_out()
    );

    logic signed [NORM_W-1:0] n_cx, n_cy;

    assign n_cx = (n_qx > NORM_ONE) ? NORM_ONE : (n_qx < NORM_MINUS_ONE) ? NORM_MINUS_ONE : n_qx;
    assign n_cy = (n_qy > NORM_ONE) ? NORM_ONE : (n_qy < NORM_MINUS_ONE) ? NORM_MINUS_ONE : n_qy;

    // Output register.
    logic                     hit_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [W-2:0]             dist_reg;
    logic signed [W-1:0]      impact_x_reg, impact_y_reg;
    logic signed [NORM_W-1:0] normal_x_reg, normal_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= n_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg      <= !n_sb.miss;
            time_reg     <= n_sb.miss ? HIT_TIME_ONE : n_sb.ht;
            dist_reg     <= n_sb.miss ? '0 : n_sb.hit_dist;
            impact_x_reg <= n_sb.miss ? '0 : n_sb.impx;
            impact_y_reg <= n_sb.miss ? '0 : n_sb.impy;
            normal_x_reg <= (n_sb.miss || n_sb.zmag) ? '0 : n_cx;
            normal_y_reg <= (n_sb.miss || n_sb.zmag) ? '0 : n_cy;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = OUT_DW'({normal_y_reg, normal_x_reg, impact_y_reg, impact_x_reg,
                                    dist_reg, time_reg});

    a_miss_time : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> time_reg == HIT_TIME_ONE && dist_reg == '0)
        else $error("miss transaction carries a nonzero result");

    a_hit_time : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> time_reg <= HIT_TIME_ONE)
        else $error("hit time exceeds one");

    a_normal_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> normal_x_reg <= NORM_ONE && normal_x_reg >= NORM_MINUS_ONE &&
                          normal_y_reg <= NORM_ONE && normal_y_reg >= NORM_MINUS_ONE)
        else $error("normal out of range");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

endmodule
